@@ rtl/core/xo256_pkg.sv @@
// Shared types, constants and microcode ROM for the xoshiro256++ generator.
// No dependencies; compiled first.
`default_nettype none

package xo256_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = WORD_W / 2;
    localparam int KIND_W = 2;
    localparam int ADDR_W = 5;
    localparam int CNT_W  = 2;
    localparam int DRAWS  = 4;

    localparam logic [WORD_W-1:0] GOLDEN_STEP   = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] MIX_MUL_A     = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] MIX_MUL_B     = 64'h94D0_49BB_1331_11EB;
    localparam logic [WORD_W-1:0] COUNTER_RESET = 64'd123;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [WORD_W-1:0] t_word;

    // Item kinds; the unused code behaves as a plain next
    typedef enum logic [KIND_W-1:0] {
        KIND_NEXT  = 2'd0,
        KIND_SEED  = 2'd1,
        KIND_RSEED = 2'd2
    } t_kind;

    // Work register operations
    typedef enum logic [2:0] {
        Z_HOLD,
        Z_SEED,     // rotl(seed, 45)
        Z_CTR,      // counter + golden step (counter advances too)
        Z_XSH30,
        Z_XSH27,
        Z_XSH31,
        Z_PROD,     // take multiplier product
        Z_XPROD     // xor in multiplier product
    } t_zop;

    // Multiplier operand select
    typedef enum logic {
        A_Z,
        A_SHOR      // (z >> 10) | (z << 4)
    } t_asel;

    // Partial product steps of the 64-bit wrapping multiply
    typedef enum logic [1:0] {
        MUL_IDLE,
        MUL_LL,
        MUL_LH,
        MUL_HL
    } t_mop;

    typedef enum logic {
        CONST_A,
        CONST_B
    } t_mconst;

    typedef struct packed {
        t_mop    op;
        t_mconst csel;
    } t_mul_ctl;

    // State word operations
    typedef enum logic [1:0] {
        W_HOLD,
        W_FILL,     // all four words take z
        W_SHIFT,    // shift z in at the top word
        W_ADV       // emit a word and advance the state
    } t_wop;

    // Sequencing
    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_JUMP,
        SEQ_DISPATCH,   // wait for an input transfer, branch on kind
        SEQ_LOOP,       // repeat target until all draws are done
        SEQ_EMIT        // wait for output space, then jump to target
    } t_seq;

    typedef struct packed {
        t_zop     zop;
        t_asel    asel;
        t_mul_ctl mul;
        t_wop     wop;
        t_seq     seq;
        t_addr    target;
    } t_cw;

    // Program entry points
    localparam t_addr ADDR_IDLE  = 5'd0;
    localparam t_addr ADDR_SEED  = 5'd1;
    localparam t_addr ADDR_FILL  = 5'd9;
    localparam t_addr ADDR_RSEED = 5'd10;
    localparam t_addr ADDR_EMIT  = 5'd23;

    function automatic t_word f_rotl23(input t_word v);
        return {v[WORD_W-24:0], v[WORD_W-1:WORD_W-23]};
    endfunction

    function automatic t_word f_rotl45(input t_word v);
        return {v[WORD_W-46:0], v[WORD_W-1:WORD_W-45]};
    endfunction

    // Microcode ROM
    function automatic t_cw f_ucode(input t_addr pc);
        t_cw cw;
        cw.zop      = Z_HOLD;
        cw.asel     = A_Z;
        cw.mul.op   = MUL_IDLE;
        cw.mul.csel = CONST_A;
        cw.wop      = W_HOLD;
        cw.seq      = SEQ_NEXT;
        cw.target   = ADDR_IDLE;
        unique case (pc)
            ADDR_IDLE: begin
                cw.zop = Z_SEED;
                cw.seq = SEQ_DISPATCH;
            end
            // seed: m = z * B
            ADDR_SEED: begin
                cw.mul.op = MUL_LL; cw.mul.csel = CONST_B;
            end
            5'd2: begin
                cw.mul.op = MUL_LH; cw.mul.csel = CONST_B;
            end
            5'd3: begin
                cw.mul.op = MUL_HL; cw.mul.csel = CONST_B;
            end
            5'd4: cw.zop = Z_PROD;
            // seed: m ^= ((m >> 10) | (m << 4)) * A
            5'd5: begin
                cw.asel = A_SHOR; cw.mul.op = MUL_LL; cw.mul.csel = CONST_A;
            end
            5'd6: begin
                cw.asel = A_SHOR; cw.mul.op = MUL_LH; cw.mul.csel = CONST_A;
            end
            5'd7: begin
                cw.asel = A_SHOR; cw.mul.op = MUL_HL; cw.mul.csel = CONST_A;
            end
            5'd8: cw.zop = Z_XPROD;
            ADDR_FILL: begin
                cw.wop    = W_FILL;
                cw.seq    = SEQ_JUMP;
                cw.target = ADDR_EMIT;
            end
            // reseed: one splitmix draw per pass
            ADDR_RSEED: cw.zop = Z_CTR;
            5'd11: cw.zop = Z_XSH30;
            5'd12: begin
                cw.mul.op = MUL_LL; cw.mul.csel = CONST_A;
            end
            5'd13: begin
                cw.mul.op = MUL_LH; cw.mul.csel = CONST_A;
            end
            5'd14: begin
                cw.mul.op = MUL_HL; cw.mul.csel = CONST_A;
            end
            5'd15: cw.zop = Z_PROD;
            5'd16: cw.zop = Z_XSH27;
            5'd17: begin
                cw.mul.op = MUL_LL; cw.mul.csel = CONST_B;
            end
            5'd18: begin
                cw.mul.op = MUL_LH; cw.mul.csel = CONST_B;
            end
            5'd19: begin
                cw.mul.op = MUL_HL; cw.mul.csel = CONST_B;
            end
            5'd20: cw.zop = Z_PROD;
            5'd21: cw.zop = Z_XSH31;
            5'd22: begin
                cw.wop    = W_SHIFT;
                cw.seq    = SEQ_LOOP;
                cw.target = ADDR_RSEED;
            end
            ADDR_EMIT: begin
                cw.wop    = W_ADV;
                cw.seq    = SEQ_EMIT;
                cw.target = ADDR_IDLE;
            end
            default: begin
                cw.seq    = SEQ_JUMP;
                cw.target = ADDR_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/xo256_in_if.sv @@
// Input channel: valid/ready with kind and seed payload.
// Depends on xo256_pkg.
`default_nettype none

interface xo256_in_if;
    logic                          valid;
    logic                          ready;
    logic [xo256_pkg::KIND_W-1:0]  kind;
    logic [xo256_pkg::WORD_W-1:0]  seed_value;

    modport source (output valid, output kind, output seed_value, input ready);
    modport sink   (input valid, input kind, input seed_value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/xo256_out_if.sv @@
// Output channel: valid/ready with the generated word.
// Depends on xo256_pkg.
`default_nettype none

interface xo256_out_if;
    logic                          valid;
    logic                          ready;
    logic [xo256_pkg::WORD_W-1:0]  random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

@@ rtl/core/xoshiro256pp_generator_top.sv @@
// xoshiro256++ generator top: microcoded sequencer over a 64-bit datapath.
// Depends on xo256_pkg, xo256_in_if, xo256_out_if, xo256_mul.
// Next items go from the dispatch step to the emit step, which registers
// the result; items are taken only at dispatch, after the last is emitted.
// Reseed runs four 13-step splitmix draws on the shared 32x32 multiplier.
// Reset: synchronous active low; state words cleared, counter set to 123.
`default_nettype none

module xoshiro256pp_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    xo256_in_if.sink    i_in,
    xo256_out_if.source o_out
);
    import xo256_pkg::*;

    t_addr             r_pc,  n_pc;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_word             r_s [4];
    t_word             n_s [4];
    t_word             r_ctr, n_ctr;
    t_word             r_z,   n_z;
    t_word             r_out, n_out;
    logic              r_out_valid, n_out_valid;

    t_cw               w_cw;
    logic              w_acc;
    logic              w_stall;
    logic              w_go;
    t_word             w_mul_a;
    t_word             w_prod;
    t_word             w_t2;
    t_word             w_t3;

    // control word fetch and step enable
    always_comb begin
        w_cw    = f_ucode(r_pc);
        w_acc   = i_in.valid && i_in.ready;
        w_stall = (w_cw.seq == SEQ_EMIT) && r_out_valid && !o_out.ready;
        w_go    = (w_cw.seq == SEQ_DISPATCH) ? w_acc : !w_stall;
    end

    assign i_in.ready        = (w_cw.seq == SEQ_DISPATCH);
    assign o_out.valid       = r_out_valid;
    assign o_out.random_word = r_out;

    // multiplier
    assign w_mul_a = (w_cw.asel == A_SHOR) ? ((r_z >> 10) | (r_z << 4)) : r_z;

    xo256_mul u_mul (
        .i_clk  (i_clk),
        .i_ctl  (w_cw.mul),
        .i_a    (w_mul_a),
        .o_prod (w_prod)
    );

    // sequencer
    always_comb begin
        n_pc  = r_pc;
        n_cnt = r_cnt;
        unique case (w_cw.seq)
            SEQ_NEXT: n_pc = r_pc + 1'b1;
            SEQ_JUMP: n_pc = w_cw.target;
            SEQ_DISPATCH: begin
                if (w_acc) begin
                    unique case (t_kind'(i_in.kind))
                        KIND_SEED:  n_pc = ADDR_SEED;
                        KIND_RSEED: n_pc = ADDR_RSEED;
                        default:    n_pc = ADDR_EMIT;
                    endcase
                end
            end
            SEQ_LOOP: begin
                if (r_cnt == CNT_W'(DRAWS - 1)) begin
                    n_pc  = r_pc + 1'b1;
                    n_cnt = '0;
                end else begin
                    n_pc  = w_cw.target;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            SEQ_EMIT: begin
                if (w_go) n_pc = w_cw.target;
            end
            default: n_pc = ADDR_IDLE;
        endcase
    end

    // work register and counter
    always_comb begin
        n_z   = r_z;
        n_ctr = r_ctr;
        if (w_go) begin
            case (w_cw.zop)
                Z_SEED:  n_z = f_rotl45(i_in.seed_value);
                Z_CTR: begin
                    n_ctr = r_ctr + GOLDEN_STEP;
                    n_z   = r_ctr + GOLDEN_STEP;
                end
                Z_XSH30: n_z = r_z ^ (r_z >> 30);
                Z_XSH27: n_z = r_z ^ (r_z >> 27);
                Z_XSH31: n_z = r_z ^ (r_z >> 31);
                Z_PROD:  n_z = w_prod;
                Z_XPROD: n_z = r_z ^ w_prod;
                default: n_z = r_z;
            endcase
        end
    end

    // state words and output register
    always_comb begin
        w_t2 = r_s[2] ^ r_s[0];
        w_t3 = r_s[3] ^ r_s[1];
        n_s  = r_s;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        if (w_go) begin
            case (w_cw.wop)
                W_FILL: begin
                    n_s[0] = r_z;
                    n_s[1] = r_z;
                    n_s[2] = r_z;
                    n_s[3] = r_z;
                end
                W_SHIFT: begin
                    n_s[0] = r_s[1];
                    n_s[1] = r_s[2];
                    n_s[2] = r_s[3];
                    n_s[3] = r_z;
                end
                W_ADV: begin
                    n_out       = f_rotl23(r_s[0] + r_s[3]) + r_s[0];
                    n_out_valid = 1'b1;
                    n_s[0]      = r_s[0] ^ w_t3;
                    n_s[1]      = r_s[1] ^ w_t2;
                    n_s[2]      = w_t2 ^ (r_s[1] << 17);
                    n_s[3]      = f_rotl45(w_t3);
                end
                default: n_s = r_s;
            endcase
        end
    end

    // control and generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= ADDR_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_ctr       <= COUNTER_RESET;
            r_s[0]      <= '0;
            r_s[1]      <= '0;
            r_s[2]      <= '0;
            r_s[3]      <= '0;
        end else begin
            r_pc        <= n_pc;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_ctr       <= n_ctr;
            r_s         <= n_s;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_z   <= n_z;
        r_out <= n_out;
    end

    // draw counter only runs inside the reseed loop
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == ADDR_IDLE) |-> (r_cnt == '0))
        else $error("draw counter not cleared at idle");

    // a next (or unused kind) transfer goes straight to the emit step
    a_next_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.kind != KIND_SEED && i_in.kind != KIND_RSEED)
        |=> (r_pc == ADDR_EMIT))
        else $error("next item did not branch to emit");

    // fill step leaves four equal words
    a_fill_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == ADDR_FILL) |=> (r_s[0] == r_s[1] && r_s[1] == r_s[2]
                                 && r_s[2] == r_s[3]))
        else $error("seed fill left unequal words");

    // a result appears only from the emit step
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_pc == ADDR_EMIT))
        else $error("result raised outside emit step");

endmodule

`default_nettype wire

@@ rtl/core/xo256_mul.sv @@
// Shared 64x64 wrapping multiplier by a mixing constant, one 32x32
// partial product per step. Depends on xo256_pkg.
`default_nettype none

module xo256_mul (
    input  logic                         i_clk,
    input  xo256_pkg::t_mul_ctl          i_ctl,
    input  logic [xo256_pkg::WORD_W-1:0] i_a,
    output logic [xo256_pkg::WORD_W-1:0] o_prod
);
    import xo256_pkg::*;

    t_word              w_b;
    logic [HALF_W-1:0]  w_ah;
    logic [HALF_W-1:0]  w_bh;
    t_word              w_pp;
    t_word              r_prod;

    // operand halves for the current partial product
    always_comb begin
        w_b  = (i_ctl.csel == CONST_A) ? MIX_MUL_A : MIX_MUL_B;
        w_ah = (i_ctl.op == MUL_HL) ? i_a[WORD_W-1:HALF_W] : i_a[HALF_W-1:0];
        w_bh = (i_ctl.op == MUL_LH) ? w_b[WORD_W-1:HALF_W] : w_b[HALF_W-1:0];
        w_pp = WORD_W'(w_ah) * WORD_W'(w_bh);
    end

    // low product, then cross terms folded into the upper half
    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            MUL_LL:         r_prod <= w_pp;
            MUL_LH, MUL_HL: r_prod <= {r_prod[WORD_W-1:HALF_W] + w_pp[HALF_W-1:0],
                                       r_prod[HALF_W-1:0]};
            default:        r_prod <= r_prod;
        endcase
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire
